>>> src/dwpid_pkg.sv
package dwpid_pkg;

  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_RIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_LEFT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_LEFT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd6;

  localparam logic [REG_W-1:0] KP_RESET    = 24'd150733;
  localparam logic [REG_W-1:0] KI_RESET    = 24'd0;
  localparam logic [REG_W-1:0] KD_RESET    = 24'd0;
  localparam logic [REG_W-1:0] SCALE_RESET = 24'd65536;

  localparam int FEEDBACK_ALPHA_Q8 = 64;
  localparam int TARGET_ALPHA_Q8   = 64;
  localparam int COUNTER_BITS      = 16;

  localparam int DELTA_W = COUNTER_BITS + 1;
  localparam int OPA_W   = (DELTA_W > 27) ? DELTA_W : 27;
  localparam int PROD_W  = OPA_W + REG_W + 1;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic signed [15:0] DUTY_LIMIT = 16'sd25600;

  localparam logic signed [25:0] TGT_KEEP  = 26'(256 - TARGET_ALPHA_Q8);
  localparam logic signed [25:0] TGT_ALPHA = 26'(TARGET_ALPHA_Q8);
  localparam logic signed [33:0] FB_KEEP   = 34'(256 - FEEDBACK_ALPHA_Q8);
  localparam logic signed [33:0] FB_ALPHA  = 34'(FEEDBACK_ALPHA_Q8);

  typedef struct packed {
    logic [REG_W-1:0] kp;
    logic [REG_W-1:0] ki;
    logic [REG_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [15:0] duty;
    logic               reverse;
  } lane_res_t;

  function automatic logic signed [15:0] lowpass_target(input logic signed [15:0] prev,
                                                        input logic signed [15:0] x);
    logic signed [25:0] s;
    s = TGT_KEEP * 26'(prev) + TGT_ALPHA * 26'(x) + 26'sd128;
    return s[23:8];
  endfunction

  function automatic logic signed [23:0] lowpass_speed(input logic signed [23:0] prev,
                                                       input logic signed [23:0] x);
    logic signed [33:0] s;
    s = FB_KEEP * 34'(prev) + FB_ALPHA * 34'(x) + 34'sd128;
    return s[31:8];
  endfunction

  function automatic logic signed [23:0] sat_err(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v > 25'(24'sh7F_FFFF)) r = 24'sh7F_FFFF;
    else if (v < 25'(24'sh80_0000)) r = 24'sh80_0000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

>>> src/dwpid_in_if.sv
interface dwpid_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_right;
  logic signed [15:0] target_left;
  logic [15:0]        count_right;
  logic [15:0]        count_left;

  modport source (output valid, target_right, target_left, count_right, count_left,
                  input ready);
  modport sink (input valid, target_right, target_left, count_right, count_left,
                output ready);
endinterface

>>> src/dwpid_out_if.sv
interface dwpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] duty_right;
  logic signed [15:0] duty_left;
  logic               reverse_right;
  logic               reverse_left;

  modport source (output valid, duty_right, duty_left, reverse_right, reverse_left,
                  input ready);
  modport sink (input valid, duty_right, duty_left, reverse_right, reverse_left,
                output ready);
endinterface

>>> src/dwpid_lane.sv
module dwpid_lane import dwpid_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [15:0]      target,
  input  logic [COUNTER_BITS-1:0] count,
  input  gains_t                  gains,
  input  logic [REG_W-1:0]        speed_scale,
  input  logic                    ack,
  output lane_res_t               res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPEED = 3'd1;
  localparam logic [2:0] ST_KP    = 3'd2;
  localparam logic [2:0] ST_KI    = 3'd3;
  localparam logic [2:0] ST_KD    = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam int CW = COUNTER_BITS + 2;
  localparam logic signed [CW-1:0] WRAP_HALF = CW'(1) <<< (COUNTER_BITS - 1);
  localparam logic signed [CW-1:0] WRAP_FULL = CW'(1) <<< COUNTER_BITS;

  logic [2:0]               step_r;
  logic                     done_r;
  logic signed [15:0]       pend_tgt_r;
  logic signed [15:0]       last_tgt_r;
  logic signed [15:0]       filt_tgt_r;
  logic signed [23:0]       last_speed_r;
  logic signed [23:0]       filt_speed_r;
  logic [COUNTER_BITS-1:0]  last_count_r;
  logic signed [23:0]       err1_r;
  logic signed [23:0]       err2_r;
  logic signed [31:0]       last_out_r;
  logic                     last_dir_r;

  logic signed [DELTA_W-1:0] delta_r;
  logic signed [23:0]        err_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [15:0]        duty_r;

  logic signed [CW-1:0]      diff;
  logic signed [CW-1:0]      diff_wrap;
  logic signed [DELTA_W-1:0] delta_nxt;
  logic signed [23:0]        err_nxt;
  logic                      dir_nxt;
  logic signed [OPA_W-1:0]   op_a;
  logic [REG_W-1:0]          op_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  spd_sh;
  logic signed [23:0]        speed_nxt;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [ACC_W-1:0]   out_sum;
  logic signed [31:0]        out_nxt;
  logic signed [15:0]        duty_nxt;

  assign diff = signed'({2'b00, count}) - signed'({2'b00, last_count_r});

  always_comb begin
    if (diff > WRAP_HALF) begin
      diff_wrap = diff - WRAP_FULL;
    end else if (diff < -WRAP_HALF) begin
      diff_wrap = diff + WRAP_FULL;
    end else begin
      diff_wrap = diff;
    end
  end

  assign delta_nxt = DELTA_W'(diff_wrap);
  assign err_nxt   = sat_err(25'(filt_tgt_r) - 25'(filt_speed_r));
  assign dir_nxt   = filt_tgt_r[15];

  always_comb begin
    unique case (step_r)
      ST_SPEED: begin
        op_a = OPA_W'(delta_r);
        op_b = speed_scale;
      end
      ST_KP: begin
        op_a = OPA_W'(err_r) - OPA_W'(err1_r);
        op_b = gains.kp;
      end
      ST_KI: begin
        op_a = OPA_W'(err_r) + OPA_W'(err1_r);
        op_b = gains.ki;
      end
      ST_KD: begin
        op_a = OPA_W'(err_r) - (OPA_W'(err1_r) <<< 1) + OPA_W'(err2_r);
        op_b = gains.kd;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * signed'({1'b0, op_b});

  assign spd_sh = (prod_r + PROD_W'(128)) >>> 8;

  always_comb begin
    if (spd_sh > PROD_W'(24'sh7F_FFFF)) begin
      speed_nxt = 24'sh7F_FFFF;
    end else if (spd_sh < PROD_W'(24'sh80_0000)) begin
      speed_nxt = 24'sh80_0000;
    end else begin
      speed_nxt = spd_sh[23:0];
    end
  end

  assign acc_sh  = (acc_r + ACC_W'(32768)) >>> 16;
  assign out_sum = acc_sh + ACC_W'(last_out_r);

  always_comb begin
    if (out_sum > ACC_W'(32'sh7FFF_FFFF)) begin
      out_nxt = 32'sh7FFF_FFFF;
    end else if (out_sum < ACC_W'(32'sh8000_0000)) begin
      out_nxt = 32'sh8000_0000;
    end else begin
      out_nxt = out_sum[31:0];
    end
  end

  always_comb begin
    if (out_nxt > 32'(DUTY_LIMIT)) begin
      duty_nxt = DUTY_LIMIT;
    end else if (out_nxt < -32'(DUTY_LIMIT)) begin
      duty_nxt = -DUTY_LIMIT;
    end else begin
      duty_nxt = out_nxt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_IDLE;
      done_r       <= 1'b0;
      pend_tgt_r   <= '0;
      last_tgt_r   <= '0;
      filt_tgt_r   <= '0;
      last_speed_r <= '0;
      filt_speed_r <= '0;
      last_count_r <= '0;
      err1_r       <= '0;
      err2_r       <= '0;
      last_out_r   <= '0;
      last_dir_r   <= 1'b0;
    end else begin
      if (ack) begin
        done_r <= 1'b0;
      end
      unique case (step_r)
        ST_IDLE: begin
          if (start) begin
            filt_tgt_r   <= lowpass_target(filt_tgt_r, last_tgt_r);
            last_tgt_r   <= pend_tgt_r;
            pend_tgt_r   <= target;
            filt_speed_r <= lowpass_speed(filt_speed_r, last_speed_r);
            last_count_r <= count;
            step_r       <= ST_SPEED;
          end
        end
        ST_SPEED: begin
          if (dir_nxt != last_dir_r) begin
            last_out_r <= '0;
            err1_r     <= '0;
            err2_r     <= '0;
          end
          last_dir_r <= dir_nxt;
          step_r     <= ST_KP;
        end
        ST_KP: begin
          last_speed_r <= speed_nxt;
          step_r       <= ST_KI;
        end
        ST_KI:  step_r <= ST_KD;
        ST_KD:  step_r <= ST_SUM;
        ST_SUM: step_r <= ST_OUT;
        ST_OUT: begin
          last_out_r <= out_nxt;
          err2_r     <= err1_r;
          err1_r     <= err_r;
          done_r     <= 1'b1;
          step_r     <= ST_IDLE;
        end
        default: step_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == ST_IDLE && start) begin
      delta_r <= delta_nxt;
    end
    if (step_r == ST_SPEED) begin
      err_r <= err_nxt;
    end
    if (step_r == ST_SPEED || step_r == ST_KP || step_r == ST_KI || step_r == ST_KD) begin
      prod_r <= prod_nxt;
    end
    if (step_r == ST_KP) begin
      acc_r <= '0;
    end else if (step_r == ST_KI || step_r == ST_KD || step_r == ST_SUM) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (step_r == ST_OUT) begin
      duty_r <= duty_nxt;
    end
  end

  assign res.busy    = (step_r != ST_IDLE) || done_r;
  assign res.done    = done_r;
  assign res.duty    = duty_r;
  assign res.reverse = duty_r[15];

endmodule

>>> src/dwpid_merge.sv
module dwpid_merge import dwpid_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lane_res_t           res_right,
  input  lane_res_t           res_left,
  output logic                ack,
  dwpid_out_if.source         out_ch
);

  logic               valid_r;
  logic signed [15:0] duty_right_r;
  logic signed [15:0] duty_left_r;
  logic               rev_right_r;
  logic               rev_left_r;

  assign ack = res_right.done && res_left.done && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ack) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      duty_right_r <= res_right.duty;
      duty_left_r  <= res_left.duty;
      rev_right_r  <= res_right.reverse;
      rev_left_r   <= res_left.reverse;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.duty_right    = duty_right_r;
  assign out_ch.duty_left     = duty_left_r;
  assign out_ch.reverse_right = rev_right_r;
  assign out_ch.reverse_left  = rev_left_r;

endmodule

>>> src/dual_wheel_incremental_pid.sv
// Each input transfer starts both wheel lanes together. Each lane runs a six-step
// sequence (speed scale, then P, I and D terms on its shared multiplier, sum, output);
// both results are then handed off together into the output register. No new input is
// accepted before that handoff, which waits while the output register is full and unread.
// The next input is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous): gains and speed scale return to their defaults,
// all filter, encoder and PID history clears, the output register empties.
module dual_wheel_incremental_pid import dwpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dwpid_in_if.sink             in_ch,
  dwpid_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  gains_t           gains_right_r;
  gains_t           gains_left_r;
  logic [REG_W-1:0] speed_scale_r;

  lane_res_t res_right;
  lane_res_t res_left;
  logic      start;
  logic      ack;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_right_r <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET};
      gains_left_r  <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET};
      speed_scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_RIGHT:    gains_right_r.kp <= cfg_data;
        REG_KI_RIGHT:    gains_right_r.ki <= cfg_data;
        REG_KD_RIGHT:    gains_right_r.kd <= cfg_data;
        REG_KP_LEFT:     gains_left_r.kp  <= cfg_data;
        REG_KI_LEFT:     gains_left_r.ki  <= cfg_data;
        REG_KD_LEFT:     gains_left_r.kd  <= cfg_data;
        REG_SPEED_SCALE: speed_scale_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !res_right.busy && !res_left.busy;
  assign start       = in_ch.valid && in_ch.ready;

  dwpid_lane u_lane_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .target      (in_ch.target_right),
    .count       (COUNTER_BITS'(in_ch.count_right)),
    .gains       (gains_right_r),
    .speed_scale (speed_scale_r),
    .ack         (ack),
    .res         (res_right)
  );

  dwpid_lane u_lane_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .target      (in_ch.target_left),
    .count       (COUNTER_BITS'(in_ch.count_left)),
    .gains       (gains_left_r),
    .speed_scale (speed_scale_r),
    .ack         (ack),
    .res         (res_left)
  );

  dwpid_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_right (res_right),
    .res_left  (res_left),
    .ack       (ack),
    .out_ch    (out_ch)
  );

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    res_right.done == res_left.done && res_right.busy == res_left.busy)
    else $error("wheel lanes out of step");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ch.ready)
    else $error("input ready while lanes work");

  a_duty_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_right <= DUTY_LIMIT && out_ch.duty_right >= -DUTY_LIMIT
                     && out_ch.reverse_right == out_ch.duty_right[15])
    else $error("right duty out of range");

  a_duty_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_left <= DUTY_LIMIT && out_ch.duty_left >= -DUTY_LIMIT
                     && out_ch.reverse_left == out_ch.duty_left[15])
    else $error("left duty out of range");

endmodule
